/* sv/qsve_pkg.sv */
package qsve_pkg;

    localparam int QSVE_MAX_QUBITS = 10;
    localparam int QSVE_AMP_BITS   = 16;

    localparam int KIND_W  = 3;
    localparam int IDX_W   = 10;
    localparam int FIELD_W = 16;
    localparam int RAND_W  = 32;
    localparam int CFG_W   = 4;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_WRITE   = 3'd0;
    localparam kind_t KIND_BASIS   = 3'd1;
    localparam kind_t KIND_CAT     = 3'd2;
    localparam kind_t KIND_EQUAL   = 3'd3;
    localparam kind_t KIND_NORM    = 3'd4;
    localparam kind_t KIND_MEASURE = 3'd5;
    localparam kind_t KIND_READ    = 3'd6;

    localparam logic [CFG_W-1:0] QUBITS_RESET = 4'd10;

    // 1/sqrt(2) as a 30-bit fraction
    localparam logic [30:0] HALF_ROOT_Q30 = 31'd759250125;

    // one * 2^(-m/2), rounded half up, with frac_bits fraction bits
    function automatic logic [31:0] root_half_pow(input logic [4:0] m,
                                                  input logic [4:0] frac_bits);
        logic [30:0] r;
        logic [5:0]  k;
        logic [31:0] t;
        r = m[0] ? HALF_ROOT_Q30 : 31'h4000_0000;
        k = 6'd30 - {1'b0, frac_bits} + {2'b00, m[4:1]};
        if (k == 6'd0)
        begin
            return {1'b0, r};
        end
        t = ({1'b0, r} >> (k - 6'd1)) + 32'd1;
        return t >> 1;
    endfunction

endpackage

/* sv/qsve_if.sv */
interface qsve_op_if;
    import qsve_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic [IDX_W-1:0]          state_index;
    logic signed [FIELD_W-1:0] write_real;
    logic signed [FIELD_W-1:0] write_imag;
    logic [RAND_W-1:0]         random_fraction;

    modport source (output valid, kind, state_index, write_real, write_imag,
                    random_fraction, input ready);
    modport sink   (input valid, kind, state_index, write_real, write_imag,
                    random_fraction, output ready);
endinterface

interface qsve_res_if;
    import qsve_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [IDX_W-1:0]          measured_index;
    logic signed [FIELD_W-1:0] read_real;
    logic signed [FIELD_W-1:0] read_imag;
    logic                      skipped;

    modport source (output valid, measured_index, read_real, read_imag, skipped,
                    input ready);
    modport sink   (input valid, measured_index, read_real, read_imag, skipped,
                    output ready);
endinterface

/* sv/qsve_div.sv */
module qsve_div #(
    parameter int QUOT_W = 17
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [63:0]       dividend,
    input  logic [32:0]       divisor,
    output logic              busy,
    output logic              ovf,
    output logic [QUOT_W-1:0] quot
);
    localparam int CNT_W  = $clog2(QUOT_W + 1);
    localparam int WIDE_W = 65 + QUOT_W;

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [32:0]       rem_reg;
    logic [32:0]       rem_next;
    logic [32:0]       div_reg;
    logic [QUOT_W-1:0] low_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic              ovf_reg;
    logic [33:0]       trial;
    logic              ge;
    logic [WIDE_W-1:0] div_wide;
    logic [63:0]       head;

    assign div_wide = WIDE_W'(divisor) << QUOT_W;
    assign head     = dividend >> QUOT_W;
    assign trial    = {rem_reg, low_reg[QUOT_W-1]};
    assign ge       = trial >= {1'b0, div_reg};
    assign rem_next = ge ? 33'(trial - {1'b0, div_reg}) : trial[32:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(QUOT_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // quotient past QUOT_W bits only ever saturates
            ovf_reg  <= WIDE_W'(dividend) >= div_wide;
            rem_reg  <= head[32:0];
            low_reg  <= dividend[QUOT_W-1:0];
            div_reg  <= divisor;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            low_reg  <= low_reg << 1;
            quot_reg <= {quot_reg[QUOT_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign ovf  = ovf_reg;
    assign quot = quot_reg;

endmodule

/* sv/qubit_state_vector_engine_core.sv */
// Amplitude store for a register of up to MAX_QUBITS qubits, one complex
// entry per basis state in a single-port-write, registered-read memory.
// One operation is in flight at a time; the next is taken once the current
// one has handed its result to the output register. Steps per operation:
// write or rejected operation, dispatch then the result hand-off; read,
// dispatch, a memory read, then the hand-off; basis, cat and equal
// superposition, a sweep over the whole memory, one entry a cycle; measure,
// a probability walk over the live entries that may stop early, then a
// collapse sweep over the whole memory; normalize, a sum over the live
// entries, scaling, a square root, then a rescale of each live entry through
// the bit-per-cycle dividers (one for each component). After reset the whole
// memory is cleared before the first operation is taken; configuration writes are accepted throughout.
module qubit_state_vector_engine_core #(
    parameter int MAX_QUBITS = qsve_pkg::QSVE_MAX_QUBITS,
    parameter int AMP_BITS   = qsve_pkg::QSVE_AMP_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [qsve_pkg::CFG_W-1:0] cfg_data,
    qsve_op_if.sink                    op_in,
    qsve_res_if.source                 res_out
);
    import qsve_pkg::*;

    localparam int DEPTH   = 1 << MAX_QUBITS;
    localparam int AW      = MAX_QUBITS;
    localparam int CW      = MAX_QUBITS + 1;
    localparam int NW      = $clog2(MAX_QUBITS + 1);
    localparam int IXW     = (CW > IDX_W) ? CW : IDX_W;
    localparam int EW      = 2 * AMP_BITS;
    localparam int QW      = AMP_BITS + 1;
    localparam int FRAC    = AMP_BITS - 2;
    localparam int TF      = 2 * FRAC;
    localparam int U_SHL   = (TF >= 32) ? TF - 32 : 0;
    localparam int A_SHL   = (TF < 32) ? 32 - TF : 0;
    localparam int UP      = (AMP_BITS >= 16) ? AMP_BITS - 16 : 0;
    localparam int DN      = (AMP_BITS < 16) ? 16 - AMP_BITS : 0;
    localparam logic [5:0] HEAD_LIM = 6'(65 - 2 * AMP_BITS);
    localparam logic [QW-1:0] LIM_POS = QW'((64'd1 << (AMP_BITS - 1)) - 64'd1);
    localparam logic [QW-1:0] LIM_NEG = QW'(64'd1 << (AMP_BITS - 1));
    localparam logic [AMP_BITS-1:0] ONE = AMP_BITS'(64'd1 << FRAC);

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_DISPATCH = 4'd2;
    localparam logic [3:0] ST_SWEEP    = 4'd3;
    localparam logic [3:0] ST_READ     = 4'd4;
    localparam logic [3:0] ST_WALK     = 4'd5;
    localparam logic [3:0] ST_HEAD     = 4'd6;
    localparam logic [3:0] ST_ROOT     = 4'd7;
    localparam logic [3:0] ST_SC_RD    = 4'd8;
    localparam logic [3:0] ST_SC_START = 4'd9;
    localparam logic [3:0] ST_SC_DIV   = 4'd10;
    localparam logic [3:0] ST_SC_WR    = 4'd11;
    localparam logic [3:0] ST_DONE     = 4'd12;

    localparam logic [1:0] FILL_ZERO  = 2'd0;
    localparam logic [1:0] FILL_BASIS = 2'd1;
    localparam logic [1:0] FILL_CAT   = 2'd2;
    localparam logic [1:0] FILL_EQUAL = 2'd3;

    logic [3:0]            state_reg;
    logic [CFG_W-1:0]      qubits_reg;
    kind_t                 kind_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic signed [FIELD_W-1:0] wre_reg;
    logic signed [FIELD_W-1:0] wim_reg;
    logic [RAND_W-1:0]     rand_reg;

    logic [IDX_W-1:0]      res_mi_reg;
    logic [FIELD_W-1:0]    res_re_reg;
    logic [FIELD_W-1:0]    res_im_reg;
    logic                  res_sk_reg;
    logic                  out_valid_reg;
    logic [IDX_W-1:0]      out_mi_reg;
    logic [FIELD_W-1:0]    out_re_reg;
    logic [FIELD_W-1:0]    out_im_reg;
    logic                  out_sk_reg;

    logic [1:0]            fill_mode_reg;
    logic [AMP_BITS-1:0]   fill_val_reg;
    logic [AW-1:0]         target_reg;
    logic [AW-1:0]         sweep_reg;

    logic                  meas_reg;
    logic [CW-1:0]         walk_reg;
    logic                  s1_v_reg;
    logic [AW-1:0]         s1_idx_reg;
    logic                  s2_v_reg;
    logic [AW-1:0]         s2_idx_reg;
    logic [63:0]           pr_reg;
    logic [63:0]           pi_reg;
    logic [63:0]           acc_reg;
    logic                  hit_reg;
    logic [AW-1:0]         pick_reg;

    logic [5:0]            h_reg;
    logic [63:0]           sq_n_reg;
    logic [63:0]           sq_res_reg;
    logic [63:0]           sq_bit_reg;
    logic [4:0]            it_reg;
    logic [31:0]           root_reg;
    logic [CW-1:0]         scale_reg;
    logic                  neg_re_reg;
    logic                  neg_im_reg;

    logic [EW-1:0]         mem [DEPTH];
    logic [EW-1:0]         rd_data_reg;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [EW-1:0]         mem_wdata;
    logic [AW-1:0]         mem_raddr;

    logic [NW-1:0]         n_live;
    logic [CW-1:0]         cnt;
    logic [CW-1:0]         last;
    logic                  in_range;
    logic [EW-1:0]         fill_data;
    logic                  walk_issue;
    logic signed [AMP_BITS-1:0] rd_re;
    logic signed [AMP_BITS-1:0] rd_im;
    logic signed [EW-1:0]  sq_re;
    logic signed [EW-1:0]  sq_im;
    logic [64:0]           acc_sum;
    logic [63:0]           acc_new;
    logic                  hit_now;
    logic [63:0]           sq_t;
    logic [63:0]           sq_res_next;
    logic [AW-1:0]         pick_final;
    logic signed [47:0]    to_re_ext;
    logic signed [47:0]    to_im_ext;
    logic signed [47:0]    from_re_ext;
    logic signed [47:0]    from_im_ext;
    logic [AMP_BITS-1:0]   mag_re;
    logic [AMP_BITS-1:0]   mag_im;
    logic [6:0]            shamt;
    logic [63:0]           dvd_re;
    logic [63:0]           dvd_im;
    logic                  div_start;
    logic                  busy_re;
    logic                  busy_im;
    logic                  ovf_re;
    logic                  ovf_im;
    logic [QW-1:0]         quot_re;
    logic [QW-1:0]         quot_im;
    logic [QW-1:0]         lim_re;
    logic [QW-1:0]         lim_im;
    logic [QW-1:0]         qs_re;
    logic [QW-1:0]         qs_im;
    logic [AMP_BITS-1:0]   new_re;
    logic [AMP_BITS-1:0]   new_im;

    // qubit count, clamped to the supported range
    always_comb
    begin
        if (int'(qubits_reg) > MAX_QUBITS)
        begin
            n_live = NW'(MAX_QUBITS);
        end
        else if (qubits_reg == '0)
        begin
            n_live = NW'(1);
        end
        else
        begin
            n_live = NW'(qubits_reg);
        end
    end

    assign cnt      = CW'(1) << n_live;
    assign last     = cnt - CW'(1);
    assign in_range = IXW'(idx_reg) < IXW'(cnt);

    always_comb
    begin
        case (fill_mode_reg)
            FILL_BASIS:
                fill_data = (sweep_reg == target_reg) ? {{AMP_BITS{1'b0}}, ONE} : '0;
            FILL_CAT:
                fill_data = (sweep_reg == '0 || CW'(sweep_reg) == last) ?
                            {{AMP_BITS{1'b0}}, fill_val_reg} : '0;
            FILL_EQUAL:
                fill_data = (CW'(sweep_reg) < cnt) ? {{AMP_BITS{1'b0}}, fill_val_reg} : '0;
            default:
                fill_data = '0;
        endcase
    end

    assign rd_re = rd_data_reg[AMP_BITS-1:0];
    assign rd_im = rd_data_reg[EW-1:AMP_BITS];
    assign sq_re = rd_re * rd_re;
    assign sq_im = rd_im * rd_im;

    // saturating running sum of squared magnitudes
    assign walk_issue = (walk_reg < cnt) && !hit_reg;
    assign acc_sum    = {1'b0, acc_reg} + {1'b0, 64'(pr_reg + pi_reg)};
    assign acc_new    = acc_sum[64] ? {64{1'b1}} : acc_sum[63:0];
    assign hit_now    = (acc_new >= (64'd1 << TF)) ||
                        ((64'(rand_reg) << U_SHL) < (acc_new << A_SHL));
    assign pick_final = hit_reg ? pick_reg : last[AW-1:0];

    assign sq_t        = sq_res_reg + sq_bit_reg;
    assign sq_res_next = (sq_n_reg >= sq_t) ? (sq_res_reg >> 1) + sq_bit_reg
                                            : sq_res_reg >> 1;

    // stored width to Q2.14 and back
    assign to_re_ext   = (48'(rd_re) >>> UP) <<< DN;
    assign to_im_ext   = (48'(rd_im) >>> UP) <<< DN;
    assign from_re_ext = (48'(wre_reg) <<< UP) >>> DN;
    assign from_im_ext = (48'(wim_reg) <<< UP) >>> DN;

    // rescale: round(|a| * one * 2^h / R) as floor((2*num + R) / (2*R))
    assign mag_re = rd_re[AMP_BITS-1] ? AMP_BITS'(-rd_re) : rd_re;
    assign mag_im = rd_im[AMP_BITS-1] ? AMP_BITS'(-rd_im) : rd_im;
    assign shamt  = 7'(FRAC) + 7'(h_reg);
    assign dvd_re = ((64'(mag_re) << shamt) << 1) + 64'(root_reg);
    assign dvd_im = ((64'(mag_im) << shamt) << 1) + 64'(root_reg);
    assign div_start = (state_reg == ST_SC_START);

    qsve_div #(.QUOT_W(QW)) u_div_re (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_re),
        .divisor  ({1'b0, root_reg} << 1),
        .busy     (busy_re),
        .ovf      (ovf_re),
        .quot     (quot_re)
    );

    qsve_div #(.QUOT_W(QW)) u_div_im (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_im),
        .divisor  ({1'b0, root_reg} << 1),
        .busy     (busy_im),
        .ovf      (ovf_im),
        .quot     (quot_im)
    );

    assign lim_re = neg_re_reg ? LIM_NEG : LIM_POS;
    assign lim_im = neg_im_reg ? LIM_NEG : LIM_POS;
    assign qs_re  = (ovf_re || quot_re > lim_re) ? lim_re : quot_re;
    assign qs_im  = (ovf_im || quot_im > lim_im) ? lim_im : quot_im;
    assign new_re = neg_re_reg ? -AMP_BITS'(qs_re) : AMP_BITS'(qs_re);
    assign new_im = neg_im_reg ? -AMP_BITS'(qs_im) : AMP_BITS'(qs_im);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = sweep_reg;
        mem_wdata = fill_data;
        case (state_reg)
            ST_CLEAR, ST_SWEEP:
            begin
                mem_we = 1'b1;
            end
            ST_DISPATCH:
            begin
                mem_we    = (kind_reg == KIND_WRITE) && in_range;
                mem_waddr = AW'(idx_reg);
                mem_wdata = {AMP_BITS'(from_im_ext), AMP_BITS'(from_re_ext)};
            end
            ST_SC_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = scale_reg[AW-1:0];
                mem_wdata = {new_im, new_re};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_WALK:  mem_raddr = walk_reg[AW-1:0];
            ST_SC_RD: mem_raddr = scale_reg[AW-1:0];
            default:  mem_raddr = AW'(idx_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qubits_reg <= QUBITS_RESET;
        end
        else if (cfg_write)
        begin
            qubits_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
            fill_mode_reg <= FILL_ZERO;
            sweep_reg     <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            if (res_out.ready && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR, ST_SWEEP:
                begin
                    sweep_reg <= sweep_reg + AW'(1);
                    if (sweep_reg == {AW{1'b1}})
                    begin
                        state_reg <= (state_reg == ST_CLEAR) ? ST_IDLE : ST_DONE;
                    end
                end

                ST_IDLE:
                begin
                    if (op_in.valid)
                    begin
                        kind_reg  <= op_in.kind;
                        idx_reg   <= op_in.state_index;
                        wre_reg   <= op_in.write_real;
                        wim_reg   <= op_in.write_imag;
                        rand_reg  <= op_in.random_fraction;
                        state_reg <= ST_DISPATCH;
                    end
                end

                ST_DISPATCH:
                begin
                    res_mi_reg <= '0;
                    res_re_reg <= '0;
                    res_im_reg <= '0;
                    sweep_reg  <= '0;
                    case (kind_reg)
                        KIND_WRITE:
                        begin
                            res_sk_reg <= !in_range;
                            state_reg  <= ST_DONE;
                        end
                        KIND_BASIS:
                        begin
                            res_sk_reg <= !in_range;
                            state_reg  <= in_range ? ST_SWEEP : ST_DONE;
                            if (in_range)
                            begin
                                fill_mode_reg <= FILL_BASIS;
                                target_reg    <= AW'(idx_reg);
                            end
                        end
                        KIND_CAT:
                        begin
                            res_sk_reg    <= 1'b0;
                            fill_mode_reg <= FILL_CAT;
                            fill_val_reg  <= AMP_BITS'(root_half_pow(5'd1, 5'(FRAC)));
                            state_reg     <= ST_SWEEP;
                        end
                        KIND_EQUAL:
                        begin
                            res_sk_reg    <= 1'b0;
                            fill_mode_reg <= FILL_EQUAL;
                            fill_val_reg  <= AMP_BITS'(root_half_pow(5'(n_live), 5'(FRAC)));
                            state_reg     <= ST_SWEEP;
                        end
                        KIND_NORM, KIND_MEASURE:
                        begin
                            res_sk_reg <= 1'b0;
                            meas_reg   <= (kind_reg == KIND_MEASURE);
                            walk_reg   <= '0;
                            s1_v_reg   <= 1'b0;
                            s2_v_reg   <= 1'b0;
                            acc_reg    <= '0;
                            hit_reg    <= 1'b0;
                            state_reg  <= ST_WALK;
                        end
                        KIND_READ:
                        begin
                            res_sk_reg <= !in_range;
                            state_reg  <= in_range ? ST_READ : ST_DONE;
                        end
                        default:
                        begin
                            res_sk_reg <= 1'b1;
                            state_reg  <= ST_DONE;
                        end
                    endcase
                end

                ST_READ:
                begin
                    res_re_reg <= to_re_ext[FIELD_W-1:0];
                    res_im_reg <= to_im_ext[FIELD_W-1:0];
                    state_reg  <= ST_DONE;
                end

                ST_WALK:
                begin
                    if (hit_reg || (!walk_issue && !s1_v_reg && !s2_v_reg))
                    begin
                        if (meas_reg)
                        begin
                            res_mi_reg    <= IDX_W'(pick_final);
                            target_reg    <= pick_final;
                            fill_mode_reg <= FILL_BASIS;
                            sweep_reg     <= '0;
                            state_reg     <= ST_SWEEP;
                        end
                        else if (acc_reg == '0)
                        begin
                            res_sk_reg <= 1'b1;
                            state_reg  <= ST_DONE;
                        end
                        else
                        begin
                            sq_n_reg  <= acc_reg;
                            h_reg     <= '0;
                            state_reg <= ST_HEAD;
                        end
                    end
                    else
                    begin
                        if (walk_issue)
                        begin
                            walk_reg <= walk_reg + CW'(1);
                        end
                        s1_v_reg   <= walk_issue;
                        s1_idx_reg <= walk_reg[AW-1:0];
                        s2_v_reg   <= s1_v_reg;
                        s2_idx_reg <= s1_idx_reg;
                        pr_reg     <= 64'($unsigned(sq_re));
                        pi_reg     <= 64'($unsigned(sq_im));
                        if (s2_v_reg)
                        begin
                            acc_reg <= acc_new;
                            if (meas_reg && hit_now)
                            begin
                                hit_reg  <= 1'b1;
                                pick_reg <= s2_idx_reg;
                            end
                        end
                    end
                end

                ST_HEAD:
                begin
                    if (h_reg < HEAD_LIM && sq_n_reg < (64'd1 << 60))
                    begin
                        sq_n_reg <= sq_n_reg << 2;
                        h_reg    <= h_reg + 6'd1;
                    end
                    else
                    begin
                        sq_res_reg <= '0;
                        sq_bit_reg <= 64'd1 << 62;
                        it_reg     <= '0;
                        state_reg  <= ST_ROOT;
                    end
                end

                ST_ROOT:
                begin
                    if (sq_n_reg >= sq_t)
                    begin
                        sq_n_reg <= sq_n_reg - sq_t;
                    end
                    sq_res_reg <= sq_res_next;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    it_reg     <= it_reg + 5'd1;
                    if (it_reg == 5'd31)
                    begin
                        root_reg  <= sq_res_next[31:0];
                        scale_reg <= '0;
                        state_reg <= ST_SC_RD;
                    end
                end

                ST_SC_RD:
                begin
                    state_reg <= ST_SC_START;
                end

                ST_SC_START:
                begin
                    neg_re_reg <= rd_re[AMP_BITS-1];
                    neg_im_reg <= rd_im[AMP_BITS-1];
                    state_reg  <= ST_SC_DIV;
                end

                ST_SC_DIV:
                begin
                    if (!busy_re && !busy_im)
                    begin
                        state_reg <= ST_SC_WR;
                    end
                end

                ST_SC_WR:
                begin
                    scale_reg <= scale_reg + CW'(1);
                    state_reg <= (scale_reg == last) ? ST_DONE : ST_SC_RD;
                end

                ST_DONE:
                begin
                    // hold the result until the output register is free
                    if (!out_valid_reg || res_out.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_mi_reg    <= res_mi_reg;
                        out_re_reg    <= res_re_reg;
                        out_im_reg    <= res_im_reg;
                        out_sk_reg    <= res_sk_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign op_in.ready            = (state_reg == ST_IDLE);
    assign res_out.valid          = out_valid_reg;
    assign res_out.measured_index = out_mi_reg;
    assign res_out.read_real      = out_re_reg;
    assign res_out.read_imag      = out_im_reg;
    assign res_out.skipped        = out_sk_reg;

endmodule

/* sv/qsve_checker.sv */
module qsve_core_props (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [qsve_pkg::IDX_W-1:0]   measured_index,
    input logic [qsve_pkg::FIELD_W-1:0] read_real,
    input logic [qsve_pkg::FIELD_W-1:0] read_imag,
    input logic                         skipped
);

    // one operation at a time: ready drops after each accepted transaction
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an operation is in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(measured_index) && $stable(read_real)
                                    && $stable(read_imag) && $stable(skipped))
        else $error("stalled result changed");

    // a skipped operation reports nothing else
    a_skip_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && skipped |-> measured_index == '0 && read_real == '0
                                 && read_imag == '0)
        else $error("skipped result carries data");

endmodule

bind qubit_state_vector_engine_core qsve_core_props u_qsve_core_props (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (op_in.valid),
    .in_ready       (op_in.ready),
    .out_valid      (res_out.valid),
    .out_ready      (res_out.ready),
    .measured_index (res_out.measured_index),
    .read_real      (res_out.read_real),
    .read_imag      (res_out.read_imag),
    .skipped        (res_out.skipped)
);

/* tb/sv/qsve_checker.sv */
module qsve_checker
    import qsve_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [CFG_W-1:0]    cfg_data,
    qsve_op_if                  op,
    qsve_res_if                 res,
    output int                  errors,
    output int                  pending,
    output int                  checked,
    output int                  measures
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int      DEPTH    = 1 << QSVE_MAX_QUBITS;
    localparam longint  AMP_ONE  = 64'sd16384;
    localparam longint  AMP_TOP  = 64'sd32767;
    localparam int      HEAD_TOP = 65 - 2 * QSVE_AMP_BITS;

    typedef struct packed {
        logic [IDX_W-1:0]          measured_index;
        logic signed [FIELD_W-1:0] read_real;
        logic signed [FIELD_W-1:0] read_imag;
        logic                      skipped;
    } outcome_t;

    int                 amp_re [DEPTH];
    int                 amp_im [DEPTH];
    logic [CFG_W-1:0]   qubit_reg;
    outcome_t           outcome_q [$];

    function automatic int active_qubits();
        int q;
        q = qubit_reg;
        if (q < 1)
        begin
            q = 1;
        end
        if (q > QSVE_MAX_QUBITS)
        begin
            q = QSVE_MAX_QUBITS;
        end
        return q;
    endfunction

    function automatic void wipe_store();
        for (int i = 0; i < DEPTH; i++)
        begin
            amp_re[i] = 0;
            amp_im[i] = 0;
        end
    endfunction

    // one * 2^(-m/2), rounded half up from a 30-bit fraction
    function automatic int amp_for_power(int m);
        longint unsigned r;
        int              k;
        r = (m % 2 == 1) ? 64'd759250125 : (64'd1 << 30);
        k = 16 + m / 2;
        return int'((r + (64'd1 << (k - 1))) >> k);
    endfunction

    function automatic longint unsigned energy(int i);
        longint r;
        longint m;
        r = amp_re[i];
        m = amp_im[i];
        return longint'(r * r) + longint'(m * m);
    endfunction

    function automatic longint unsigned add_clip(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s < a) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (n >= root + b)
            begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end
            else
            begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic int scale_amp(int a, int h, longint unsigned root);
        logic            neg;
        longint unsigned mag;
        longint unsigned num;
        longint unsigned q;
        longint unsigned lim;
        neg = a < 0;
        mag = neg ? longint'(-longint'(a)) : longint'(a);
        num = (mag * AMP_ONE) << h;
        q   = (2 * num + root) / (2 * root);
        lim = neg ? AMP_TOP + 1 : AMP_TOP;
        if (q > lim)
        begin
            q = lim;
        end
        return neg ? -int'(q) : int'(q);
    endfunction

    function automatic outcome_t predict_op(kind_t kind, logic [IDX_W-1:0] idx,
                                            logic signed [FIELD_W-1:0] wr,
                                            logic signed [FIELD_W-1:0] wi,
                                            logic [RAND_W-1:0] u);
        outcome_t        o;
        int              cnt;
        int              v;
        int              h;
        int              pick;
        longint unsigned s;
        o = '0;
        cnt = 1 << active_qubits();
        case (kind)
            KIND_WRITE:
            begin
                if (idx >= cnt)
                begin
                    o.skipped = 1'b1;
                end
                else
                begin
                    amp_re[idx] = wr;
                    amp_im[idx] = wi;
                end
            end
            KIND_BASIS:
            begin
                if (idx >= cnt)
                begin
                    o.skipped = 1'b1;
                end
                else
                begin
                    wipe_store();
                    amp_re[idx] = int'(AMP_ONE);
                end
            end
            KIND_CAT:
            begin
                v = amp_for_power(1);
                wipe_store();
                amp_re[0] = v;
                amp_re[cnt-1] = v;
            end
            KIND_EQUAL:
            begin
                v = amp_for_power(active_qubits());
                wipe_store();
                for (int i = 0; i < cnt; i++)
                begin
                    amp_re[i] = v;
                end
            end
            KIND_NORM:
            begin
                s = 0;
                for (int i = 0; i < cnt; i++)
                begin
                    s = add_clip(s, energy(i));
                end
                if (s == 0)
                begin
                    o.skipped = 1'b1;
                end
                else
                begin
                    h = 0;
                    while (h < HEAD_TOP && s < (64'd1 << 60))
                    begin
                        s = s << 2;
                        h++;
                    end
                    s = int_sqrt(s);
                    for (int i = 0; i < cnt; i++)
                    begin
                        amp_re[i] = scale_amp(amp_re[i], h, s);
                        amp_im[i] = scale_amp(amp_im[i], h, s);
                    end
                end
            end
            KIND_MEASURE:
            begin
                s = 0;
                pick = cnt - 1;
                for (int i = 0; i < cnt; i++)
                begin
                    s = add_clip(s, energy(i));
                    if (s >= (64'd1 << 28) || longint'(u) < (s << 4))
                    begin
                        pick = i;
                        break;
                    end
                end
                wipe_store();
                amp_re[pick] = int'(AMP_ONE);
                o.measured_index = pick[IDX_W-1:0];
            end
            KIND_READ:
            begin
                if (idx >= cnt)
                begin
                    o.skipped = 1'b1;
                end
                else
                begin
                    o.read_real = amp_re[idx][FIELD_W-1:0];
                    o.read_imag = amp_im[idx][FIELD_W-1:0];
                end
            end
            default:
            begin
                o.skipped = 1'b1;
            end
        endcase
        return o;
    endfunction

    assign pending = outcome_q.size();

    initial
    begin
        errors = 0;
        checked = 0;
        measures = 0;
        qubit_reg = QUBITS_RESET;
        wipe_store();
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                qubit_reg <= cfg_data;
            end
            if (op.valid && op.ready)
            begin
                outcome_q.push_back(predict_op(op.kind, op.state_index, op.write_real,
                                               op.write_imag, op.random_fraction));
                if (op.kind == KIND_MEASURE)
                begin
                    measures++;
                end
            end
            if (res.valid && res.ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("unexpected result transaction");
                    errors++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    checked++;
                    if (res.measured_index !== want.measured_index)
                    begin
                        $error("measured_index: expected %0d, got %0d",
                               want.measured_index, res.measured_index);
                        errors++;
                    end
                    if (res.read_real !== want.read_real)
                    begin
                        $error("read_real: expected %0d, got %0d",
                               want.read_real, res.read_real);
                        errors++;
                    end
                    if (res.read_imag !== want.read_imag)
                    begin
                        $error("read_imag: expected %0d, got %0d",
                               want.read_imag, res.read_imag);
                        errors++;
                    end
                    if (res.skipped !== want.skipped)
                    begin
                        $error("skipped: expected %0d, got %0d", want.skipped, res.skipped);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

/* tb/sv/tb_qubit_state_vector_engine_core.sv */
module tb_qubit_state_vector_engine_core;
    import qsve_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam kind_t KIND_UNUSED = 3'd7;
    localparam int    CYCLE_LIMIT = 2000000;

    logic             clk;
    logic             rst_n;
    logic             cfg_write;
    logic [CFG_W-1:0] cfg_data;
    logic             calm;
    int               live_n;
    int               sent;
    int               errors;
    int               pending;
    int               checked;
    int               measures;
    int               cycles;

    qsve_op_if  op_bus ();
    qsve_res_if res_bus ();

    qubit_state_vector_engine_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .op_in     (op_bus),
        .res_out   (res_bus)
    );

    qsve_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .op        (op_bus),
        .res       (res_bus),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked),
        .measures  (measures)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("tb_qubit_state_vector_engine_core NOT OK");
                $finish;
            end
        end
    end

    // result side: random stalls, one long hold-off to back the block up
    initial
    begin
        int stall;
        int taken;
        res_bus.ready = 1'b0;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 5);
            if (taken == 30)
            begin
                stall = 400;
            end
            if (stall > 0)
            begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_bus.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!res_bus.valid);
            taken++;
        end
    end

    task automatic send_op(kind_t kind, int idx, logic [FIELD_W-1:0] wr,
                           logic [FIELD_W-1:0] wi, logic [RAND_W-1:0] u);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            op_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op_bus.valid           <= 1'b1;
        op_bus.kind            <= kind;
        op_bus.state_index     <= idx[IDX_W-1:0];
        op_bus.write_real      <= wr;
        op_bus.write_imag      <= wi;
        op_bus.random_fraction <= u;
        do
        begin
            @(posedge clk);
        end
        while (!op_bus.ready);
        sent++;
    endtask

    // drop valid and drain all outstanding transactions
    task automatic settle();
        op_bus.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
    endtask

    task automatic set_qubits(int n);
        settle();
        cfg_write <= 1'b1;
        cfg_data  <= n[CFG_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        live_n = (n < 1) ? 1 : (n > QSVE_MAX_QUBITS) ? QSVE_MAX_QUBITS : n;
    endtask

    function automatic logic [FIELD_W-1:0] draw_amp();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return FIELD_W'($urandom());
        endcase
    endfunction

    function automatic int draw_index();
        if ($urandom_range(0, 99) < 88)
        begin
            return $urandom_range(0, (1 << live_n) - 1);
        end
        return $urandom_range(0, 1023);
    endfunction

    task automatic random_op();
        int   pick;
        kind_t k;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            k = KIND_WRITE;
        end
        else if (pick < 52)
        begin
            k = KIND_READ;
        end
        else if (pick < 60)
        begin
            k = KIND_BASIS;
        end
        else if (pick < 66)
        begin
            k = KIND_CAT;
        end
        else if (pick < 72)
        begin
            k = KIND_EQUAL;
        end
        else if (pick < 82)
        begin
            k = (live_n <= 6) ? KIND_NORM : KIND_READ;
        end
        else if (pick < 97)
        begin
            k = KIND_MEASURE;
        end
        else
        begin
            k = KIND_UNUSED;
        end
        send_op(k, draw_index(), draw_amp(), draw_amp(), $urandom());
    endtask

    // load a few amplitudes, normalise if live_n <= 6, then read, measure, read
    task automatic prepared_run();
        int loads;
        loads = $urandom_range(1, 4);
        if ($urandom_range(0, 1) == 1)
        begin
            send_op(KIND_EQUAL, 0, 0, 0, 0);
        end
        for (int i = 0; i < loads; i++)
        begin
            send_op(KIND_WRITE, $urandom_range(0, (1 << live_n) - 1),
                    draw_amp(), draw_amp(), 0);
        end
        if (live_n <= 6)
        begin
            send_op(KIND_NORM, 0, 0, 0, 0);
        end
        send_op(KIND_READ, $urandom_range(0, (1 << live_n) - 1), 0, 0, 0);
        send_op(KIND_MEASURE, 0, 0, 0, $urandom());
        send_op(KIND_READ, $urandom_range(0, (1 << live_n) - 1), 0, 0, 0);
    endtask

    initial
    begin
        int settings [] = '{0, 15, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 3, 2};
        int phase_start;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = '0;
        calm = 1'b0;
        live_n = QSVE_MAX_QUBITS;
        sent = 0;
        op_bus.valid = 1'b0;
        op_bus.kind = KIND_WRITE;
        op_bus.state_index = '0;
        op_bus.write_real = '0;
        op_bus.write_imag = '0;
        op_bus.random_fraction = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: ten qubits from reset
        send_op(KIND_READ, 0, 0, 0, 0);
        send_op(KIND_WRITE, 1023, 16'h7FFF, 16'h8000, 0);
        send_op(KIND_READ, 1023, 0, 0, 0);
        send_op(KIND_WRITE, 0, 16'h8000, 16'h7FFF, 0);
        send_op(KIND_NORM, 0, 0, 0, 0);
        send_op(KIND_READ, 0, 0, 0, 0);
        send_op(KIND_READ, 1023, 0, 0, 0);
        send_op(KIND_MEASURE, 0, 0, 0, 32'h0000_0000);
        send_op(KIND_CAT, 0, 0, 0, 0);
        send_op(KIND_READ, 1023, 0, 0, 0);
        send_op(KIND_MEASURE, 0, 0, 0, 32'hFFFF_FFFF);
        send_op(KIND_EQUAL, 0, 0, 0, 0);
        send_op(KIND_READ, 5, 0, 0, 0);
        send_op(KIND_BASIS, 512, 0, 0, 0);
        send_op(KIND_READ, 512, 0, 0, 0);
        send_op(KIND_UNUSED, 0, 0, 0, 0);

        // directed: one qubit, out-of-range indices, zero norm, fallback collapse
        set_qubits(1);
        send_op(KIND_WRITE, 2, 16'h1234, 16'h4321, 0);
        send_op(KIND_BASIS, 3, 0, 0, 0);
        send_op(KIND_READ, 1023, 0, 0, 0);
        send_op(KIND_BASIS, 1, 0, 0, 0);
        send_op(KIND_WRITE, 1, 0, 0, 0);
        send_op(KIND_NORM, 0, 0, 0, 0);
        send_op(KIND_MEASURE, 0, 0, 0, 32'h0000_0000);
        send_op(KIND_EQUAL, 0, 0, 0, 0);
        send_op(KIND_READ, 1, 0, 0, 0);

        foreach (settings[p])
        begin
            set_qubits(settings[p]);
            calm = (p % 4 == 3);
            phase_start = sent;
            while (sent - phase_start < 16)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    prepared_run();
                end
                else
                begin
                    random_op();
                end
            end
        end

        settle();
        repeat (50) @(posedge clk);
        $display("Ran %0d operations over %0d qubit settings: %0d results checked, %0d measures.",
                 sent, settings.size() + 2, checked, measures);
        if (errors == 0)
        begin
            $display("tb_qubit_state_vector_engine_core OK");
        end
        else
        begin
            $display("tb_qubit_state_vector_engine_core NOT OK");
        end
        $finish;
    end

endmodule
